[rtl/core/tic_pkg.sv]
// Package: shared types, codes and constants for the tape interface command channel.
package tic_pkg;

  localparam int unsigned RecordMax = 65536;
  localparam int unsigned CountW = $clog2(RecordMax + 1);

  typedef enum logic [1:0] {
    OP_CMD   = 2'd0,
    OP_DATA  = 2'd1,
    OP_EVENT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [7:0] F_CLR = 8'o300;
  localparam logic [7:0] F_WC  = 8'o031;
  localparam logic [7:0] F_RC  = 8'o023;
  localparam logic [7:0] F_GAP = 8'o011;
  localparam logic [7:0] F_FSR = 8'o003;
  localparam logic [7:0] F_BSR = 8'o041;
  localparam logic [7:0] F_REW = 8'o201;
  localparam logic [7:0] F_RWS = 8'o101;
  localparam logic [7:0] F_WFM = 8'o035;

  localparam logic [8:0] S_LOCAL = 9'o400;
  localparam logic [8:0] S_EOF   = 9'o200;
  localparam logic [8:0] S_BOT   = 9'o100;
  localparam logic [8:0] S_TIM   = 9'o020;
  localparam logic [8:0] S_REJ   = 9'o010;
  localparam logic [8:0] S_WLK   = 9'o004;
  localparam logic [8:0] S_PAR   = 9'o002;
  localparam logic [8:0] S_BUSY  = 9'o001;

  localparam logic [CountW-1:0] ShortRecord = CountW'(12);

  // Signal bit positions.
  localparam int unsigned B_POPIO = 0;
  localparam int unsigned B_CRS = 1;
  localparam int unsigned B_CLF = 2;
  localparam int unsigned B_STF = 3;
  localparam int unsigned B_ENF = 4;
  localparam int unsigned B_SFC = 5;
  localparam int unsigned B_SFS = 6;
  localparam int unsigned B_IOI = 7;
  localparam int unsigned B_IOO = 8;
  localparam int unsigned B_CLC = 9;
  localparam int unsigned B_STC = 10;
  localparam int unsigned B_IAK = 11;
  localparam int unsigned B_IEN = 12;
  localparam int unsigned B_SIR = 13;
  localparam int unsigned B_PRH = 14;

  localparam logic [2:0] EV_READ = 3'd0;
  localparam logic [2:0] EV_WSLOT = 3'd1;
  localparam logic [2:0] EV_DONE = 3'd2;
  localparam logic [2:0] EV_MARK = 3'd3;
  localparam logic [2:0] EV_PARITY = 3'd4;
  localparam logic [2:0] EV_BOT = 3'd5;
  localparam logic [2:0] EV_REWOUND = 3'd6;
  localparam logic [2:0] EV_UNLOAD = 3'd7;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] signals;
    logic [15:0] data_in;
    logic        online;
    logic        write_locked;
    logic [2:0]  drive_event;
  } req_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        skip;
    logic        service_request;
    logic        interrupt_request;
    logic        priority_low;
    logic        start_command;
    logic [7:0]  function_code;
    logic [7:0]  write_byte;
    logic        write_byte_valid;
    logic        record_end;
    logic        clear_issued;
  } rsp_t;

  // Classified request, passed from front to back.
  typedef struct packed {
    req_t req;
    logic legal_cmd;
    logic write_cmd;
  } cls_t;

  function automatic logic is_legal(input logic [7:0] d);
    return d == F_WC || d == F_RC || d == F_GAP || d == F_FSR ||
           d == F_BSR || d == F_REW || d == F_RWS || d == F_WFM;
  endfunction

endpackage

[rtl/core/tic_req_if.sv]
// Interfaces: request and response channels with valid/ready handshake.
interface tic_req_if import tic_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tic_rsp_if import tic_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/tape_interface_command_channel.sv]
// Top level: tape controller command and data channel service logic.
//
//   channel   direction  payload
//   in        sink       op, signals, data_in, online, write_locked, drive_event
//   out       source     read_value, skip, SRQ, IRQ, PRL, start, function, write byte
//
// One request per cycle sustained while the consumer is ready; a stalled
// consumer holds requests back. Each request produces exactly one response.
// A request is held in the front end's two-entry queue, then the back end's
// single state update registers the response in its output register, where
// it waits out any output stall. Synchronous reset clears the control flops,
// not queue or response data; the front queue lets requests in while
// the output waits on a stalled consumer, until the queue fills.
module tape_interface_command_channel import tic_pkg::*; (
  input logic clk,
  input logic rst,
  tic_req_if.sink in,
  tic_rsp_if.source out
);
  logic q_valid, q_ready;
  cls_t q_item;

  // Accept and classify.
  tic_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in.valid), .in_ready(in.ready), .in_req(in.payload),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  // Advance controller state and register the response.
  tic_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out.valid), .out_ready(out.ready), .out_rsp(out.payload)
  );
endmodule

[rtl/core/tic_front.sv]
// Front end: accept requests, classify commands, hold them in a two-entry queue.
module tic_front import tic_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic q_valid,
  input  logic q_ready,
  output cls_t q_item
);
  cls_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic push, pop;
  cls_t cls;

  always_comb begin
    cls.req = in_req;
    cls.legal_cmd = is_legal(in_req.data_in[7:0]);
    cls.write_cmd = in_req.data_in[7:0] == F_WC || in_req.data_in[7:0] == F_GAP ||
                    in_req.data_in[7:0] == F_WFM;
  end

  assign in_ready = cnt != 2'd2;
  assign push = in_valid && in_ready;
  assign q_valid = cnt != 2'd0;
  assign pop = q_valid && q_ready;
  assign q_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/core/tic_back.sv]
// Back end: controller state, signal sequencing and drive event handling.
module tic_back import tic_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  cls_t q_item,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);
  logic cctl, cflg, cfbf, dflg, dfbf, busy, xfer, fsvc;
  logic [8:0] stat;
  logic [7:0] afn, dbyte;
  logic [CountW-1:0] cnt;

  logic cctl_next, cflg_next, cfbf_next, dflg_next, dfbf_next;
  logic busy_next, xfer_next, fsvc_next;
  logic [8:0] stat_next;
  logic [7:0] afn_next, dbyte_next;
  logic [CountW-1:0] cnt_next;
  rsp_t o;
  logic take;

  assign q_ready = !out_valid || out_ready;
  assign take = q_valid && q_ready;

  always_comb begin
    req_t r;
    logic [14:0] s;
    logic irq_en, cn_irq, cn_prl;
    logic [15:0] v;
    r = q_item.req;
    s = r.signals;
    irq_en = 1'b0; cn_irq = 1'b0; cn_prl = 1'b0; v = '0;
    cctl_next = cctl; cflg_next = cflg; cfbf_next = cfbf;
    dflg_next = dflg; dfbf_next = dfbf; busy_next = busy;
    xfer_next = xfer; fsvc_next = fsvc; stat_next = stat;
    afn_next = afn; dbyte_next = dbyte; cnt_next = cnt;
    o = '0;
    case (op_t'(r.op))
      OP_CMD: begin
        if (s[B_POPIO] || s[B_CLF]) begin
          cfbf_next = 1'b0; cflg_next = 1'b0;
        end
        if (s[B_CRS]) cctl_next = 1'b0;
        if (s[B_STF]) cfbf_next = 1'b1;
        if (s[B_ENF] && cfbf_next) cflg_next = 1'b1;
        if (s[B_SFC] && !cflg_next) o.skip = 1'b1;
        if (s[B_SFS] && cflg_next) o.skip = 1'b1;
        if (s[B_IOI]) begin
          v = {7'd0, stat_next & ~(S_LOCAL | S_WLK | S_BUSY)};
          if (r.online) begin
            if (busy_next) v[0] = 1'b1;
            if (r.write_locked) v[2] = 1'b1;
          end else begin
            v = v | {7'd0, S_BUSY | S_LOCAL};
          end
          o.read_value = v;
        end
        if (s[B_IOO]) begin
          stat_next = stat_next & ~S_REJ;
          if (r.data_in[7:0] == F_CLR) begin
            o.clear_issued = 1'b1;
            if (busy_next && afn_next == F_WC && cnt_next != '0) o.record_end = 1'b1;
            if (busy_next && (afn_next == F_REW || afn_next == F_RWS)) busy_next = 1'b0;
            fsvc_next = 1'b0; xfer_next = 1'b0;
            stat_next = stat_next & S_BOT;
            dfbf_next = 1'b0; dflg_next = 1'b0;
            cfbf_next = 1'b1; cflg_next = 1'b1;
          end else if (!q_item.legal_cmd || busy_next ||
                       (stat_next[6] && r.data_in[7:0] == F_BSR) ||
                       (r.online && r.write_locked && q_item.write_cmd)) begin
            stat_next = stat_next | S_REJ;
          end else begin
            o.start_command = 1'b1;
            o.function_code = r.data_in[7:0];
            afn_next = r.data_in[7:0];
            stat_next = S_BUSY;
            busy_next = 1'b1;
            cnt_next = '0;
            dfbf_next = 1'b0; dflg_next = 1'b0;
            cfbf_next = 1'b0; cflg_next = 1'b0;
            fsvc_next = 1'b1; xfer_next = 1'b1;
          end
        end
        if (s[B_CLC]) cctl_next = 1'b0;
        if (s[B_STC]) cctl_next = 1'b1;
        if (s[B_IAK]) cfbf_next = 1'b0;
        if (s[B_IEN]) irq_en = 1'b1;
        if (s[B_SIR]) begin
          if (!(cctl_next && cflg_next)) cn_prl = 1'b1;
          if (cctl_next && cflg_next && cfbf_next) cn_irq = 1'b1;
          if (cflg_next) o.service_request = 1'b1;
        end
        if (s[B_PRH]) begin
          if (irq_en && cn_irq) o.interrupt_request = 1'b1;
          if (!irq_en || cn_prl) o.priority_low = 1'b1;
        end
      end
      OP_DATA: begin
        if (s[B_POPIO]) begin
          o.clear_issued = 1'b1;
          if (busy && afn == F_WC && cnt != '0) o.record_end = 1'b1;
          if (busy && (afn == F_REW || afn == F_RWS)) busy_next = 1'b0;
          fsvc_next = 1'b0; xfer_next = 1'b0;
          stat_next = stat & S_BOT;
          dfbf_next = 1'b0;
        end
        if (s[B_CLF]) begin
          dfbf_next = 1'b0; dflg_next = 1'b0;
        end
        if (s[B_STF]) dfbf_next = 1'b1;
        if (s[B_ENF] && dfbf_next) dflg_next = 1'b1;
        if (s[B_SFC] && !dflg_next) o.skip = 1'b1;
        if (s[B_SFS] && dflg_next) o.skip = 1'b1;
        if (s[B_IOI]) o.read_value = {8'd0, dbyte};
        if (s[B_IOO]) dbyte_next = r.data_in[7:0];
        if (s[B_CLC]) begin
          dfbf_next = 1'b0; dflg_next = 1'b0; xfer_next = 1'b0;
        end
        if (s[B_SIR] && dflg_next) o.service_request = 1'b1;
        if (s[B_PRH]) o.priority_low = 1'b1;
      end
      OP_EVENT: begin
        if (!busy) begin
        end else if (r.drive_event == EV_UNLOAD) begin
          stat_next = stat & ~S_BUSY; busy_next = 1'b0;
        end else if (!r.online) begin
          stat_next = S_LOCAL | S_REJ;
          cfbf_next = 1'b1; cflg_next = 1'b1; busy_next = 1'b0;
        end else begin
          case (r.drive_event)
            EV_READ: begin
              if (afn == F_RC) begin
                fsvc_next = 1'b0;
                if (cnt < CountW'(RecordMax)) cnt_next = cnt + 1'b1;
                if (xfer) begin
                  if (dflg) stat_next = stat | S_TIM;
                  dbyte_next = r.data_in[7:0];
                  dfbf_next = 1'b1; dflg_next = 1'b1;
                end
              end
            end
            EV_WSLOT: begin
              if (afn == F_WC) begin
                if (fsvc) fsvc_next = 1'b0;
                else if (cnt < CountW'(RecordMax)) begin
                  o.write_byte = dbyte; o.write_byte_valid = 1'b1;
                  cnt_next = cnt + 1'b1;
                  stat_next = stat & ~S_BOT;
                end else stat_next = stat | S_PAR;
                if (xfer) begin
                  dfbf_next = 1'b1; dflg_next = 1'b1;
                end else begin
                  if (cnt_next != '0) o.record_end = 1'b1;
                  cfbf_next = 1'b1; cflg_next = 1'b1;
                  stat_next = stat_next & ~S_BUSY; busy_next = 1'b0;
                end
              end
            end
            EV_DONE, EV_REWOUND: begin
              busy_next = 1'b0;
              if (afn == F_RWS) stat_next = stat & ~S_BUSY;
              else begin
                if (r.drive_event == EV_REWOUND || afn == F_REW) stat_next = S_BOT;
                else if (afn == F_WFM) stat_next = S_EOF;
                else if (afn == F_RC && cnt < ShortRecord) stat_next = stat | S_PAR;
                else stat_next = stat;
                stat_next = stat_next & ~S_BUSY;
                cfbf_next = 1'b1; cflg_next = 1'b1;
              end
            end
            EV_MARK: begin
              stat_next = (stat | S_EOF) & ~S_BUSY; busy_next = 1'b0;
              cfbf_next = 1'b1; cflg_next = 1'b1;
            end
            EV_PARITY: begin
              stat_next = (stat | S_PAR) & ~S_BUSY; busy_next = 1'b0;
              cfbf_next = 1'b1; cflg_next = 1'b1;
            end
            default: begin
              stat_next = (stat | S_BOT) & ~S_BUSY; busy_next = 1'b0;
              cfbf_next = 1'b1; cflg_next = 1'b1;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cctl <= 1'b0; cflg <= 1'b0; cfbf <= 1'b0; dflg <= 1'b0; dfbf <= 1'b0;
      busy <= 1'b0; xfer <= 1'b0; fsvc <= 1'b0; stat <= '0; afn <= '0;
      dbyte <= '0; cnt <= '0; out_valid <= 1'b0;
    end else begin
      if (take) begin
        cctl <= cctl_next; cflg <= cflg_next; cfbf <= cfbf_next;
        dflg <= dflg_next; dfbf <= dfbf_next; busy <= busy_next;
        xfer <= xfer_next; fsvc <= fsvc_next; stat <= stat_next;
        afn <= afn_next; dbyte <= dbyte_next; cnt <= cnt_next;
        out_rsp <= o;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

[rtl/core/tic_checker.sv]
// Checker: port-level properties of the tape interface, bound to the top level.
module tic_checker import tic_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_payload
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("response dropped under stall");
  a_start_fc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.start_command |-> out_payload.function_code != 8'd0)
    else $error("start without function");
  a_fc_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.start_command |-> out_payload.function_code == 8'd0)
    else $error("function without start");
  a_wb: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_payload.write_byte_valid |-> out_payload.write_byte == 8'd0)
    else $error("write byte without valid");
endmodule

bind tape_interface_command_channel tic_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out.valid), .out_ready(out.ready),
  .out_payload(out.payload)
);
